[hdl/qphm_pkg.sv]
// shared types and constants of the quadratic probe hash map
`default_nettype none

package qphm_pkg;

   // fixed field widths
   localparam int CMD_WIDTH    = 2;
   localparam int KEY_WIDTH    = 30;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;
   localparam int MARK_WIDTH   = 2;

   // home slot remainder unit: hash word consumed HASH_BITS bits a step
   localparam int HASH_WORD   = 32;
   localparam int HASH_BITS   = 4;
   localparam int HASH_STEPS  = HASH_WORD / HASH_BITS;
   localparam int HCNT_WIDTH  = $clog2(HASH_STEPS);

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2
   } status_type;

   typedef enum logic [MARK_WIDTH-1:0] {
      MARK_NEVER = 2'd0,
      MARK_USED  = 2'd1,
      MARK_GONE  = 2'd2
   } mark_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic clr_step;
      logic hash_step;
      logic probe_init;
      logic probe_step;
      logic finish;
      logic resp_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_fire;
      logic req_bad;
      logic clr_done;
      logic hash_done;
      logic probe_end;
      logic rsp_free;
   } ctl_sts_type;

endpackage

`default_nettype wire

[hdl/qphm_req_if.sv]
// request channel: command, key and value words
`default_nettype none

interface qphm_req_if #(
   parameter int VALUE_WIDTH = 32
) ();
   logic                           valid;
   logic                           ready;
   logic [qphm_pkg::CMD_WIDTH-1:0] cmd;
   logic [qphm_pkg::KEY_WIDTH-1:0] key_in;
   logic [VALUE_WIDTH-1:0]         value_in;

   modport source (output valid, output cmd, output key_in, output value_in, input ready);
   modport sink   (input valid, input cmd, input key_in, input value_in, output ready);
endinterface

`default_nettype wire

[hdl/qphm_rsp_if.sv]
// response channel: status, value and entry count words
`default_nettype none

interface qphm_rsp_if #(
   parameter int VALUE_WIDTH = 32
) ();
   logic                              valid;
   logic                              ready;
   logic [qphm_pkg::STATUS_WIDTH-1:0] status;
   logic [VALUE_WIDTH-1:0]            value_out;
   logic [qphm_pkg::COUNT_WIDTH-1:0]  entry_count;

   modport source (output valid, output status, output value_out, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input value_out, input entry_count,
                   output ready);
endinterface

`default_nettype wire

[hdl/quadratic_probe_hash_map.sv]
// top level of the quadratic probe hash map
//
//   channel   direction  words                               handshake
//   req_port  in         cmd, key_in, value_in               valid / ready
//   rsp_port  out        status, value_out, entry_count      valid / ready
//
// After reset the slot marks are cleared one slot a cycle, all CAPACITY of them,
// with req_port.ready low.
// One word: the accept, the home slot remainder (4 hash bits a cycle), then one slot
// read a cycle through the mark and key/value memories until the walk ends, then the
// registered memory read and the response; the walk reads up to CAPACITY slots.
// Unused command codes skip the walk and answer key not found.
// A finished response waits in its register while the next word is accepted;
// a stalled rsp_port holds only the response cycle of the following word.
`default_nettype none

module quadratic_probe_hash_map #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   qphm_req_if.sink   req_port,
   qphm_rsp_if.source rsp_port
);

   qphm_pkg::ctl_cmd_type ctl;
   qphm_pkg::ctl_sts_type sts;

   qphm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   qphm_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts),
      .req   (req_port),
      .rsp   (rsp_port)
   );

endmodule

`default_nettype wire

[hdl/qphm_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module qphm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/qphm_ctrl.sv]
// controller state machine of the hash map
`default_nettype none

module qphm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qphm_pkg::ctl_sts_type sts,
   output      qphm_pkg::ctl_cmd_type ctl
);

   qphm_pkg::state_type state_ff, state_in;

   // state register, clearing pass first after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qphm_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         qphm_pkg::S_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = qphm_pkg::S_IDLE;
            end
         end
         qphm_pkg::S_IDLE: begin
            ctl.take = 1'b1;
            if (sts.req_fire) begin
               state_in = sts.req_bad ? qphm_pkg::S_RESP : qphm_pkg::S_HASH;
            end
         end
         qphm_pkg::S_HASH: begin
            if (sts.hash_done) begin
               ctl.probe_init = 1'b1;
               state_in       = qphm_pkg::S_PROBE;
            end else begin
               ctl.hash_step = 1'b1;
            end
         end
         qphm_pkg::S_PROBE: begin
            ctl.probe_step = 1'b1;
            if (sts.probe_end) begin
               ctl.finish = 1'b1;
               state_in   = qphm_pkg::S_RESP;
            end
         end
         qphm_pkg::S_RESP: begin
            if (sts.rsp_free) begin
               ctl.resp_load = 1'b1;
               state_in      = qphm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = qphm_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/qphm_datapath.sv]
// datapath: request registers, home slot unit, probe walker, slot stores, response
`default_nettype none

module qphm_datapath #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qphm_pkg::ctl_cmd_type ctl,
   output      qphm_pkg::ctl_sts_type sts,
   qphm_req_if.sink                   req,
   qphm_rsp_if.source                 rsp
);

   localparam int IDXW = $clog2(CAPACITY);
   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int KVW  = qphm_pkg::KEY_WIDTH + VALUE_WIDTH;
   localparam logic [IDXW:0] CAP_W  = (IDXW + 1)'(CAPACITY);
   localparam logic [IDXW:0] LAST_J = (IDXW + 1)'(CAPACITY - 1);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);
   localparam logic [qphm_pkg::HCNT_WIDTH-1:0] LAST_HSTEP =
      qphm_pkg::HCNT_WIDTH'(qphm_pkg::HASH_STEPS - 1);

   // HASH_BITS remainder steps: rem = (rem * 2 + bit) mod CAPACITY per bit
   function automatic logic [IDXW-1:0] rem_step(input logic [IDXW-1:0] rem,
                                                input logic [qphm_pkg::HASH_BITS-1:0] bits);
      logic [IDXW:0] r;
      r = {1'b0, rem};
      for (int i = qphm_pkg::HASH_BITS - 1; i >= 0; i--) begin
         r = {r[IDXW-1:0], bits[i]};
         if (r >= CAP_W) begin
            r = r - CAP_W;
         end
      end
      return r[IDXW-1:0];
   endfunction

   // request word
   qphm_pkg::cmd_type                cmd_ff, cmd_in;
   logic [qphm_pkg::KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0]           val_ff, val_in;
   logic                             load;
   logic [qphm_pkg::KEY_WIDTH:0]     hval;

   // home slot unit
   logic [qphm_pkg::HASH_WORD-1:0]   shreg_ff, shreg_in;
   logic [IDXW-1:0]                  rem_ff, rem_in;
   logic [qphm_pkg::HCNT_WIDTH-1:0]  hcnt_ff, hcnt_in;
   logic                             hdone_ff, hdone_in;

   // probe walker
   logic [IDXW-1:0]                  pos_ff, pos_in;
   logic [IDXW-1:0]                  dlt_ff, dlt_in;
   logic [IDXW:0]                    jcnt_ff, jcnt_in;
   logic [IDXW:0]                    pos_sum, dlt_sum;
   logic                             issue;
   logic [IDXW-1:0]                  rd_pos_ff, rd_pos_in;
   logic                             rd_last_ff, rd_last_in;
   logic                             rd_vld_ff, rd_vld_in;

   // clearing pass
   logic [IDXW-1:0]                  clr_idx_ff, clr_idx_in;

   // slot stores
   logic                             mark_we;
   logic [IDXW-1:0]                  mark_waddr;
   logic [qphm_pkg::MARK_WIDTH-1:0]  mark_wdata;
   logic [qphm_pkg::MARK_WIDTH-1:0]  mark_rdata;
   logic                             kv_we;
   logic [KVW-1:0]                   kv_rdata;
   qphm_pkg::mark_type               mark_q;
   logic [qphm_pkg::KEY_WIDTH-1:0]   key_q;
   logic [VALUE_WIDTH-1:0]           val_q;
   logic                             slot_free, slot_match, slot_never;
   logic                             ins_ok, rem_hit;

   // occupancy and results
   logic [CNTW-1:0]                  count_ff, count_in;
   qphm_pkg::status_type             res_status_ff, res_status_in;
   logic [VALUE_WIDTH-1:0]           res_value_ff, res_value_in;
   logic [CNTW+qphm_pkg::COUNT_WIDTH-1:0] cnt_wide;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   qphm_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0]           rsp_value_ff, rsp_value_in;
   logic [qphm_pkg::COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   // request handshake
   assign req.ready = ctl.take;
   assign load      = ctl.take & req.valid;
   assign hval      = {req.key_in, 1'b0} | {6'b0, req.key_in[qphm_pkg::KEY_WIDTH-1:5]};

   assign sts.req_fire = load;
   assign sts.req_bad  = (req.cmd != qphm_pkg::CMD_INSERT) &&
                         (req.cmd != qphm_pkg::CMD_REMOVE) &&
                         (req.cmd != qphm_pkg::CMD_LOOKUP);

   // request registers and home slot remainder
   always_comb begin
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      hcnt_in  = hcnt_ff;
      hdone_in = hdone_ff;
      if (load) begin
         cmd_in   = qphm_pkg::cmd_type'(req.cmd);
         key_in   = req.key_in;
         val_in   = req.value_in;
         shreg_in = {1'b0, hval};
         rem_in   = '0;
         hcnt_in  = '0;
         hdone_in = 1'b0;
      end else if (ctl.hash_step) begin
         rem_in   = rem_step(rem_ff,
                             shreg_ff[qphm_pkg::HASH_WORD-1 -: qphm_pkg::HASH_BITS]);
         shreg_in = {shreg_ff[qphm_pkg::HASH_WORD-qphm_pkg::HASH_BITS-1:0],
                     {qphm_pkg::HASH_BITS{1'b0}}};
         hcnt_in  = hcnt_ff + 1'b1;
         hdone_in = (hcnt_ff == LAST_HSTEP);
      end
   end

   assign sts.hash_done = hdone_ff;

   // probe walker: slot advances by 2j+1, both kept below the capacity
   assign pos_sum = {1'b0, pos_ff} + {1'b0, dlt_ff};
   assign dlt_sum = {1'b0, dlt_ff} + (IDXW + 1)'(2);
   assign issue   = ctl.probe_step && (jcnt_ff < CAP_W);

   always_comb begin
      pos_in     = pos_ff;
      dlt_in     = dlt_ff;
      jcnt_in    = jcnt_ff;
      rd_pos_in  = rd_pos_ff;
      rd_last_in = rd_last_ff;
      rd_vld_in  = 1'b0;
      if (ctl.probe_init) begin
         pos_in  = rem_ff;
         dlt_in  = IDXW'(1);
         jcnt_in = '0;
      end else if (issue) begin
         pos_in     = (pos_sum >= CAP_W) ? IDXW'(pos_sum - CAP_W) : pos_sum[IDXW-1:0];
         dlt_in     = (dlt_sum >= CAP_W) ? IDXW'(dlt_sum - CAP_W) : dlt_sum[IDXW-1:0];
         jcnt_in    = jcnt_ff + 1'b1;
         rd_pos_in  = pos_ff;
         rd_last_in = (jcnt_ff == LAST_J);
         rd_vld_in  = 1'b1;
      end
   end

   // slot word returned by the read issued last cycle
   assign mark_q     = qphm_pkg::mark_type'(mark_rdata);
   assign key_q      = kv_rdata[KVW-1 -: qphm_pkg::KEY_WIDTH];
   assign val_q      = kv_rdata[VALUE_WIDTH-1:0];
   assign slot_free  = (mark_q != qphm_pkg::MARK_USED);
   assign slot_never = (mark_q == qphm_pkg::MARK_NEVER);
   assign slot_match = (mark_q == qphm_pkg::MARK_USED) && (key_q == key_ff);

   always_comb begin
      if (cmd_ff == qphm_pkg::CMD_INSERT) begin
         sts.probe_end = rd_vld_ff && (slot_free || rd_last_ff);
      end else begin
         sts.probe_end = rd_vld_ff && (slot_never || slot_match || rd_last_ff);
      end
   end

   assign ins_ok  = ctl.finish && (cmd_ff == qphm_pkg::CMD_INSERT) && slot_free;
   assign rem_hit = ctl.finish && (cmd_ff == qphm_pkg::CMD_REMOVE) && slot_match;

   // clearing pass over the slot marks
   assign clr_idx_in   = ctl.clr_step ? clr_idx_ff + 1'b1 : clr_idx_ff;
   assign sts.clr_done = (clr_idx_ff == LAST_IDX);

   // store writes
   always_comb begin
      mark_we    = ctl.clr_step | ins_ok | rem_hit;
      mark_waddr = ctl.clr_step ? clr_idx_ff : rd_pos_ff;
      if (ctl.clr_step) begin
         mark_wdata = qphm_pkg::MARK_NEVER;
      end else if (ins_ok) begin
         mark_wdata = qphm_pkg::MARK_USED;
      end else begin
         mark_wdata = qphm_pkg::MARK_GONE;
      end
   end

   assign kv_we = ins_ok;

   qphm_ram #(
      .WIDTH (qphm_pkg::MARK_WIDTH),
      .DEPTH (CAPACITY)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_addr (pos_ff),
      .rd_data (mark_rdata)
   );

   qphm_ram #(
      .WIDTH (KVW),
      .DEPTH (CAPACITY)
   ) u_kv_ram (
      .clock   (clock),
      .wr_en   (kv_we),
      .wr_addr (rd_pos_ff),
      .wr_data ({key_ff, val_ff}),
      .rd_addr (pos_ff),
      .rd_data (kv_rdata)
   );

   // occupancy and result of the walk
   always_comb begin
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      if (load) begin
         res_status_in = qphm_pkg::STAT_NOT_FOUND;
         res_value_in  = '0;
      end else if (ctl.finish) begin
         unique case (cmd_ff)
            qphm_pkg::CMD_INSERT: begin
               if (slot_free) begin
                  res_status_in = qphm_pkg::STAT_OK;
                  count_in      = count_ff + CNTW'(1);
               end else begin
                  res_status_in = qphm_pkg::STAT_FULL;
               end
            end
            qphm_pkg::CMD_REMOVE: begin
               if (slot_match) begin
                  res_status_in = qphm_pkg::STAT_OK;
                  count_in      = count_ff - CNTW'(1);
               end
            end
            qphm_pkg::CMD_LOOKUP: begin
               if (slot_match) begin
                  res_status_in = qphm_pkg::STAT_OK;
                  res_value_in  = val_q;
               end
            end
            default: begin
               res_status_in = qphm_pkg::STAT_NOT_FOUND;
            end
         endcase
      end
   end

   // response register, refilled only when empty or being taken
   assign cnt_wide     = {{qphm_pkg::COUNT_WIDTH{1'b0}}, count_ff};
   assign sts.rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      if (ctl.resp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = res_value_ff;
         rsp_count_in  = cnt_wide[qphm_pkg::COUNT_WIDTH-1:0];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.value_out   = rsp_value_ff;
   assign rsp.entry_count = rsp_count_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdone_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         clr_idx_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hdone_ff     <= hdone_in;
         rd_vld_ff    <= rd_vld_in;
         clr_idx_ff   <= clr_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      shreg_ff      <= shreg_in;
      rem_ff        <= rem_in;
      hcnt_ff       <= hcnt_in;
      pos_ff        <= pos_in;
      dlt_ff        <= dlt_in;
      jcnt_ff       <= jcnt_in;
      rd_pos_ff     <= rd_pos_in;
      rd_last_ff    <= rd_last_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // occupancy never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(CAPACITY))
      else $error("occupancy above capacity");

   // walker stays inside the table while probing
   assert property (@(posedge clock) disable iff (reset)
      ctl.probe_step |-> (pos_ff < IDXW'(CAPACITY - 1) || pos_ff == LAST_IDX) &&
                         (dlt_ff < IDXW'(CAPACITY - 1) || dlt_ff == LAST_IDX))
      else $error("probe slot outside table");

   // the last probe of a walk always ends it
   assert property (@(posedge clock) disable iff (reset)
      (ctl.probe_step && rd_vld_ff && rd_last_ff) |-> sts.probe_end)
      else $error("walk ran past its last probe");

   // a successful insert adds one entry
   assert property (@(posedge clock) disable iff (reset)
      ins_ok |=> count_ff == $past(count_ff) + CNTW'(1))
      else $error("insert did not count the new entry");

   // a successful remove drops one entry
   assert property (@(posedge clock) disable iff (reset)
      rem_hit |=> count_ff == $past(count_ff) - CNTW'(1))
      else $error("remove did not drop the entry");

endmodule

`default_nettype wire
